### rtl/core/dual_probe_safety_trip_latch_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dual probe safety trip latch
// Concurrent checks that drop out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef DUAL_PROBE_SAFETY_TRIP_LATCH_ASSERT_SVH
`define DUAL_PROBE_SAFETY_TRIP_LATCH_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, reset masked
`define DPSTL_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dpstl: same-cycle check failed");

// next-cycle implication, reset masked
`define DPSTL_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dpstl: next-cycle check failed");

`else

`define DPSTL_ASSERT_IMP(name, clk, rst_n, ante, cons)

`define DPSTL_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

### rtl/core/dpstl_pkg.sv
// ----------------------------------------------------------------------------
// dpstl_pkg
// Shared widths, register indexes, trip codes and types of the trip latch.
// ----------------------------------------------------------------------------
`default_nettype none

package dpstl_pkg;

    localparam int TEMP_BITS = 14;
    localparam int RUN_BITS  = 8;

    localparam int LIMIT_W  = 13;
    localparam int MARGIN_W = 10;
    localparam int SPREAD_W = 12;
    localparam int RUNCFG_W = 8;

    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 3;

    // signed compare width: holds any temp, any limit and limit - margin
    localparam int CMP_BITS = ((TEMP_BITS > LIMIT_W) ? TEMP_BITS : LIMIT_W) + 1;
    // run compare width
    localparam int CNT_CMP_W = (RUN_BITS > RUNCFG_W) ? RUN_BITS : RUNCFG_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CODE_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ONE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_TWO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_MARG  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLD_CEIL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_LIM  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FAULT_RUN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_RUN   = 3'd6;

    localparam logic [LIMIT_W-1:0]  RST_LIMIT_ONE  = 13'd1000;
    localparam logic [LIMIT_W-1:0]  RST_LIMIT_TWO  = 13'd1200;
    localparam logic [MARGIN_W-1:0] RST_CLEAR_MARG = 10'd40;
    localparam logic [LIMIT_W-1:0]  RST_COLD_CEIL  = 13'd200;
    localparam logic [SPREAD_W-1:0] RST_SPREAD_LIM = 12'd40;
    localparam logic [RUNCFG_W-1:0] RST_FAULT_RUN  = 8'd3;
    localparam logic [RUNCFG_W-1:0] RST_CLEAR_RUN  = 8'd10;

    localparam logic [CODE_W-1:0] CODE_NONE       = 3'd0;
    localparam logic [CODE_W-1:0] CODE_OVER_ONE   = 3'd1;
    localparam logic [CODE_W-1:0] CODE_OVER_TWO   = 3'd2;
    localparam logic [CODE_W-1:0] CODE_SENSOR_ONE = 3'd3;
    localparam logic [CODE_W-1:0] CODE_SENSOR_TWO = 3'd4;
    localparam logic [CODE_W-1:0] CODE_SPREAD     = 3'd5;

    typedef struct packed {
        logic [LIMIT_W-1:0]  limit_one;
        logic [LIMIT_W-1:0]  limit_two;
        logic [MARGIN_W-1:0] clear_margin;
        logic [LIMIT_W-1:0]  cold_ceiling;
        logic [SPREAD_W-1:0] spread_limit;
        logic [RUNCFG_W-1:0] fault_run_needed;
        logic [RUNCFG_W-1:0] clear_run_needed;
    } cfg_t;

    // classified sample as it travels from front to back
    typedef struct packed {
        logic over_one;
        logic over_two;
        logic fault_one;
        logic fault_two;
        logic spread;
        logic healthy;
    } cls_t;

endpackage

`default_nettype wire

### rtl/core/dpstl_front.sv
// ----------------------------------------------------------------------------
// dpstl_front
// Accepts a probe sample and reduces it to trip and health flags.
// ----------------------------------------------------------------------------
`default_nettype none

module dpstl_front (
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic signed [dpstl_pkg::TEMP_BITS-1:0] probe_one_temp,
    input  wire logic                                   probe_one_valid,
    input  wire logic                                   probe_one_fault,
    input  wire logic signed [dpstl_pkg::TEMP_BITS-1:0] probe_two_temp,
    input  wire logic                                   probe_two_valid,
    input  wire logic                                   probe_two_fault,
    input  wire dpstl_pkg::cfg_t                        cfg,
    input  wire logic                                   q_full,
    output logic                                        q_push,
    output dpstl_pkg::cls_t                             q_data
);

    import dpstl_pkg::*;

    logic signed [CMP_BITS-1:0] t1_x;
    logic signed [CMP_BITS-1:0] t2_x;
    logic signed [CMP_BITS-1:0] lim1_x;
    logic signed [CMP_BITS-1:0] lim2_x;
    logic signed [CMP_BITS-1:0] marg_x;
    logic signed [CMP_BITS-1:0] cold_x;
    logic signed [CMP_BITS-1:0] clr1_x;
    logic signed [CMP_BITS-1:0] clr2_x;
    logic signed [CMP_BITS-1:0] diff;
    logic        [CMP_BITS-1:0] abs_diff;
    logic                       both_cold;
    logic                       spread;

    assign t1_x   = CMP_BITS'(probe_one_temp);
    assign t2_x   = CMP_BITS'(probe_two_temp);
    assign lim1_x = $signed(CMP_BITS'(cfg.limit_one));
    assign lim2_x = $signed(CMP_BITS'(cfg.limit_two));
    assign marg_x = $signed(CMP_BITS'(cfg.clear_margin));
    assign cold_x = $signed(CMP_BITS'(cfg.cold_ceiling));
    assign clr1_x = lim1_x - marg_x;
    assign clr2_x = lim2_x - marg_x;

    assign diff     = t1_x - t2_x;
    assign abs_diff = diff[CMP_BITS-1] ? unsigned'(-diff) : unsigned'(diff);

    assign both_cold = (t1_x < cold_x) && (t2_x < cold_x);
    assign spread    = probe_one_valid && probe_two_valid && both_cold &&
                       (abs_diff > CMP_BITS'(cfg.spread_limit));

    always_comb
    begin
        q_data.over_one  = probe_one_valid && (t1_x >= lim1_x);
        q_data.over_two  = probe_two_valid && (t2_x >= lim2_x);
        q_data.fault_one = probe_one_fault;
        q_data.fault_two = probe_two_fault;
        q_data.spread    = spread;
        q_data.healthy   = !probe_one_fault && !probe_two_fault &&
                           probe_one_valid && probe_two_valid && !spread &&
                           (t1_x <= clr1_x) && (t2_x <= clr2_x);
    end

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

endmodule

`default_nettype wire

### rtl/core/dpstl_queue.sv
// ----------------------------------------------------------------------------
// dpstl_queue
// Short queue of classified samples between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dual_probe_safety_trip_latch_assert.svh"

module dpstl_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire dpstl_pkg::cls_t wr_data,
    output logic                 full,
    input  wire logic            pop,
    output logic                 not_empty,
    output dpstl_pkg::cls_t      rd_data
);

    import dpstl_pkg::*;

    cls_t                entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `DPSTL_ASSERT_IMP(a_no_push_full, clk, rst_n, push, !full)
    `DPSTL_ASSERT_IMP(a_no_pop_empty, clk, rst_n, pop, not_empty)
    `DPSTL_ASSERT_IMP(a_empty_ptrs, clk, rst_n, !not_empty, rd_ptr_reg == wr_ptr_reg)

endmodule

`default_nettype wire

### rtl/core/dpstl_back.sv
// ----------------------------------------------------------------------------
// dpstl_back
// Run counters, trip latch and output register of the trip latch.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dual_probe_safety_trip_latch_assert.svh"

module dpstl_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire dpstl_pkg::cfg_t              cfg,
    input  wire logic                         q_not_empty,
    input  wire dpstl_pkg::cls_t              q_data,
    output logic                              q_pop,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              trip_active,
    output logic [dpstl_pkg::CODE_W-1:0]      trip_code,
    output logic                              tripped_now,
    output logic                              cleared_now
);

    import dpstl_pkg::*;

    localparam logic [RUN_BITS-1:0] RUN_MAX = '1;

    logic                trip_reg;
    logic                trip_next;
    logic [CODE_W-1:0]   held_reg;
    logic [CODE_W-1:0]   held_next;
    logic [RUN_BITS-1:0] one_run_reg;
    logic [RUN_BITS-1:0] one_run_next;
    logic [RUN_BITS-1:0] two_run_reg;
    logic [RUN_BITS-1:0] two_run_next;
    logic [RUN_BITS-1:0] spread_run_reg;
    logic [RUN_BITS-1:0] spread_run_next;
    logic [RUN_BITS-1:0] healthy_run_reg;
    logic [RUN_BITS-1:0] healthy_run_next;
    logic [RUN_BITS-1:0] healthy_inc;
    logic [CODE_W-1:0]   new_code;
    logic                tripped;
    logic                cleared;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                trip_active_reg;
    logic [CODE_W-1:0]   trip_code_reg;
    logic                tripped_now_reg;
    logic                cleared_now_reg;

    function automatic logic [RUN_BITS-1:0] run_step(input logic [RUN_BITS-1:0] run,
                                                     input logic              hit);
        logic [RUN_BITS-1:0] res;
        if (!hit)
        begin
            res = '0;
        end
        else if (run == RUN_MAX)
        begin
            res = RUN_MAX;
        end
        else
        begin
            res = run + 1'b1;
        end
        return res;
    endfunction

    function automatic logic run_reached(input logic [RUN_BITS-1:0] run,
                                         input logic [RUNCFG_W-1:0] needed);
        return CNT_CMP_W'(run) >= CNT_CMP_W'(needed);
    endfunction

    // take the next item whenever the output register is free or draining
    assign q_pop = q_not_empty && (!out_valid_reg || !out_stall);

    always_comb
    begin
        one_run_next    = run_step(one_run_reg, q_data.fault_one);
        two_run_next    = run_step(two_run_reg, q_data.fault_two);
        spread_run_next = run_step(spread_run_reg, q_data.spread);
        healthy_inc     = run_step(healthy_run_reg, q_data.healthy);

        new_code = CODE_NONE;
        if (q_data.over_one)
        begin
            new_code = CODE_OVER_ONE;
        end
        else if (q_data.over_two)
        begin
            new_code = CODE_OVER_TWO;
        end
        else if (run_reached(one_run_next, cfg.fault_run_needed))
        begin
            new_code = CODE_SENSOR_ONE;
        end
        else if (run_reached(two_run_next, cfg.fault_run_needed))
        begin
            new_code = CODE_SENSOR_TWO;
        end
        else if (run_reached(spread_run_next, cfg.fault_run_needed))
        begin
            new_code = CODE_SPREAD;
        end

        trip_next        = trip_reg;
        held_next        = held_reg;
        healthy_run_next = healthy_run_reg;
        tripped          = 1'b0;
        cleared          = 1'b0;
        if (!trip_reg)
        begin
            if (new_code != CODE_NONE)
            begin
                trip_next        = 1'b1;
                held_next        = new_code;
                healthy_run_next = '0;
                tripped          = 1'b1;
            end
        end
        else
        begin
            healthy_run_next = healthy_inc;
            if (run_reached(healthy_inc, cfg.clear_run_needed))
            begin
                trip_next        = 1'b0;
                held_next        = CODE_NONE;
                healthy_run_next = '0;
                cleared          = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (q_pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trip_reg        <= 1'b0;
            held_reg        <= CODE_NONE;
            one_run_reg     <= '0;
            two_run_reg     <= '0;
            spread_run_reg  <= '0;
            healthy_run_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                trip_reg        <= trip_next;
                held_reg        <= held_next;
                one_run_reg     <= one_run_next;
                two_run_reg     <= two_run_next;
                spread_run_reg  <= spread_run_next;
                healthy_run_reg <= healthy_run_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            trip_active_reg <= trip_next;
            trip_code_reg   <= held_next;
            tripped_now_reg <= tripped;
            cleared_now_reg <= cleared;
        end
    end

    assign out_valid   = out_valid_reg;
    assign trip_active = trip_active_reg;
    assign trip_code   = trip_code_reg;
    assign tripped_now = tripped_now_reg;
    assign cleared_now = cleared_now_reg;

    `DPSTL_ASSERT_IMP(a_clear_no_code, clk, rst_n, !trip_reg, held_reg == CODE_NONE)
    `DPSTL_ASSERT_IMP(a_trip_has_code, clk, rst_n, trip_reg, held_reg != CODE_NONE)
    `DPSTL_ASSERT_NXT(a_pop_shows, clk, rst_n, q_pop,
                      out_valid_reg && (trip_active_reg == trip_reg) && (trip_code_reg == held_reg))
    `DPSTL_ASSERT_IMP(a_event_excl, clk, rst_n, out_valid_reg,
                      !(tripped_now_reg && cleared_now_reg))

endmodule

`default_nettype wire

### rtl/core/dual_probe_safety_trip_latch.sv
// ----------------------------------------------------------------------------
// dual_probe_safety_trip_latch
// Over-limit, sensor-fault and cold-spread trip latch for two probes.
// ----------------------------------------------------------------------------
// One sample is taken per clock while the front is not stalled, and each
// sample yields exactly one result. An accepted sample is classified and
// written into the queue, then moves into the output register when that
// register is free or draining. The front stalls only when the two-entry
// queue is full; the output register and the queue let the input keep
// flowing while a result waits. The back part updates the run counters and
// the latch once for each item taken from the queue. Configuration
// registers may be written only while no sample is in flight.
`default_nettype none

module dual_probe_safety_trip_latch (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic [dpstl_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [dpstl_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic signed [dpstl_pkg::TEMP_BITS-1:0] probe_one_temp,
    input  wire logic                                   probe_one_valid,
    input  wire logic                                   probe_one_fault,
    input  wire logic signed [dpstl_pkg::TEMP_BITS-1:0] probe_two_temp,
    input  wire logic                                   probe_two_valid,
    input  wire logic                                   probe_two_fault,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic                                        trip_active,
    output logic [dpstl_pkg::CODE_W-1:0]                trip_code,
    output logic                                        tripped_now,
    output logic                                        cleared_now
);

    import dpstl_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    cls_t front_cls;
    cls_t queue_cls;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_not_empty;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_LIMIT_ONE:  cfg_next.limit_one        = cfg_data[LIMIT_W-1:0];
                CFG_LIMIT_TWO:  cfg_next.limit_two        = cfg_data[LIMIT_W-1:0];
                CFG_CLEAR_MARG: cfg_next.clear_margin     = cfg_data[MARGIN_W-1:0];
                CFG_COLD_CEIL:  cfg_next.cold_ceiling     = cfg_data[LIMIT_W-1:0];
                CFG_SPREAD_LIM: cfg_next.spread_limit     = cfg_data[SPREAD_W-1:0];
                CFG_FAULT_RUN:  cfg_next.fault_run_needed = cfg_data[RUNCFG_W-1:0];
                CFG_CLEAR_RUN:  cfg_next.clear_run_needed = cfg_data[RUNCFG_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.limit_one        <= RST_LIMIT_ONE;
            cfg_reg.limit_two        <= RST_LIMIT_TWO;
            cfg_reg.clear_margin     <= RST_CLEAR_MARG;
            cfg_reg.cold_ceiling     <= RST_COLD_CEIL;
            cfg_reg.spread_limit     <= RST_SPREAD_LIM;
            cfg_reg.fault_run_needed <= RST_FAULT_RUN;
            cfg_reg.clear_run_needed <= RST_CLEAR_RUN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    dpstl_front u_front (
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .probe_one_temp  (probe_one_temp),
        .probe_one_valid (probe_one_valid),
        .probe_one_fault (probe_one_fault),
        .probe_two_temp  (probe_two_temp),
        .probe_two_valid (probe_two_valid),
        .probe_two_fault (probe_two_fault),
        .cfg             (cfg_reg),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_data          (front_cls)
    );

    dpstl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wr_data   (front_cls),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .rd_data   (queue_cls)
    );

    dpstl_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_data      (queue_cls),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .trip_active (trip_active),
        .trip_code   (trip_code),
        .tripped_now (tripped_now),
        .cleared_now (cleared_now)
    );

endmodule

`default_nettype wire
